/* hw/rtl/ihex_pkg.sv */
// Package with the shared types, constants and helpers of the Intel HEX parser.
package ihex_pkg;

  localparam int unsigned POS_W = 10;

  localparam logic [POS_W-1:0] POS_WAIT = '0;
  localparam logic [POS_W-1:0] POS_TAIL = '1;
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] D_COUNT_LO = POS_W'(1);
  localparam logic [POS_W-1:0] D_ADDR_HI_LO = POS_W'(3);
  localparam logic [POS_W-1:0] D_ADDR_LO_LO = POS_W'(5);
  localparam logic [POS_W-1:0] D_TYPE_LO = POS_W'(7);
  localparam logic [POS_W-1:0] FIRST_DATA_DIGIT = POS_W'(8);
  localparam logic [POS_W-1:0] CHK_BASE = POS_W'(9);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF = 8'h01;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [2:0] {
    ST_DATA_BYTE = 3'd0,
    ST_DATA_OK   = 3'd1,
    ST_EOF_OK    = 3'd2,
    ST_FORMAT    = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_DONE_OK   = 3'd5,
    ST_DONE_FAIL = 3'd6
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t h;
    h.ok  = 1'b1;
    h.nib = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.nib = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* hw/rtl/ihex_if.sv */
// Handshake interfaces for the character input and result output channels.
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface ihex_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] address;
  logic [7:0]  data_byte;

  modport source (output valid, output status, output address, output data_byte,
                  input ready);
  modport sink (input valid, input status, input address, input data_byte,
                output ready);
endinterface

/* hw/rtl/ihex_in_stage.sv */
// Input register that captures one word and passes it on when the parser advances.
module ihex_in_stage
  import ihex_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ihex_char_if.sink char_in,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  held_valid;
  item_t held;

  assign char_in.ready = !held_valid || advance;
  assign item_valid    = held_valid;
  assign item          = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (char_in.ready) begin
      held_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      held.kind      <= char_in.kind;
      held.char_code <= char_in.char_code;
    end
  end

endmodule

/* hw/rtl/ihex_parser.sv */
// Record parser state and the combinational update for one character or end word.
module ihex_parser
  import ihex_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  logic [POS_W-1:0] char_position, char_position_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic [7:0]       rec_len, rec_len_next;
  logic [15:0]      record_address, record_address_next;
  logic [7:0]       record_type, record_type_next;
  logic [7:0]       running_sum, running_sum_next;
  logic             eof_seen, eof_seen_next;
  logic             error_flag, error_flag_next;

  hex_digit_t       hd;
  logic [POS_W-1:0] d;
  logic [POS_W-1:0] chk_digit;
  logic [POS_W-1:0] idx;
  logic [7:0]       value;
  logic [7:0]       sum_new;
  logic [7:0]       c;
  logic             ok;

  assign c         = item.char_code;
  assign hd        = hex_value(c);
  assign d         = char_position - POS_FIRST;
  assign chk_digit = CHK_BASE + {1'b0, rec_len, 1'b0};
  assign idx       = (d - FIRST_DATA_DIGIT) >> 1;
  assign value     = {high_nibble, hd.nib};
  assign sum_new   = running_sum + value;
  assign ok        = !error_flag && eof_seen &&
                     (char_position == POS_WAIT || char_position == POS_TAIL);

  always_comb begin
    char_position_next  = char_position;
    high_nibble_next    = high_nibble;
    rec_len_next        = rec_len;
    record_address_next = record_address;
    record_type_next    = record_type;
    running_sum_next    = running_sum;
    eof_seen_next       = eof_seen;
    error_flag_next     = error_flag;
    res_valid           = 1'b0;
    res.status          = ST_DATA_BYTE;
    res.address         = '0;
    res.data_byte       = '0;

    if (item.kind == KIND_END) begin
      char_position_next  = POS_WAIT;
      high_nibble_next    = '0;
      rec_len_next        = '0;
      record_address_next = '0;
      record_type_next    = '0;
      running_sum_next    = '0;
      eof_seen_next       = 1'b0;
      error_flag_next     = 1'b0;
      res_valid           = 1'b1;
      res.status          = ok ? ST_DONE_OK : ST_DONE_FAIL;
    end else if (error_flag || eof_seen) begin
      // Everything after an error or an end-of-file record is dropped.
    end else if (char_position == POS_TAIL) begin
      if (c == CH_CR || c == CH_LF) begin
        char_position_next = POS_WAIT;
      end
    end else if (char_position == POS_WAIT) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        // Whitespace between records.
      end else if (c != CH_COLON) begin
        error_flag_next = 1'b1;
        res_valid       = 1'b1;
        res.status      = ST_FORMAT;
      end else begin
        char_position_next  = POS_FIRST;
        running_sum_next    = '0;
        rec_len_next        = '0;
        record_address_next = '0;
        record_type_next    = '0;
        high_nibble_next    = '0;
      end
    end else if (!hd.ok) begin
      error_flag_next    = 1'b1;
      char_position_next = POS_WAIT;
      res_valid          = 1'b1;
      res.status         = ST_FORMAT;
    end else begin
      char_position_next = char_position + POS_FIRST;
      if (!d[0]) begin
        high_nibble_next = hd.nib;
      end else begin
        running_sum_next = sum_new;
        if (d == D_COUNT_LO) begin
          rec_len_next = value;
        end else if (d == D_ADDR_HI_LO) begin
          record_address_next = {value, 8'h00};
        end else if (d == D_ADDR_LO_LO) begin
          record_address_next = {record_address[15:8], value};
        end else if (d == D_TYPE_LO) begin
          record_type_next = value;
          if (value != REC_DATA && value != REC_EOF) begin
            error_flag_next    = 1'b1;
            char_position_next = POS_WAIT;
            res_valid          = 1'b1;
            res.status         = ST_FORMAT;
          end
        end else if (d < chk_digit) begin
          if (record_type == REC_DATA) begin
            res_valid     = 1'b1;
            res.status    = ST_DATA_BYTE;
            res.address   = record_address + 16'(idx);
            res.data_byte = value;
          end
        end else if (sum_new != 8'h00) begin
          error_flag_next    = 1'b1;
          char_position_next = POS_WAIT;
          res_valid          = 1'b1;
          res.status         = ST_CHECKSUM;
          res.address        = record_address;
        end else begin
          char_position_next = POS_TAIL;
          res_valid          = 1'b1;
          res.address        = record_address;
          if (record_type == REC_EOF) begin
            eof_seen_next = 1'b1;
            res.status    = ST_EOF_OK;
          end else begin
            res.status = ST_DATA_OK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= POS_WAIT;
      high_nibble    <= '0;
      rec_len        <= '0;
      record_address <= '0;
      record_type    <= '0;
      running_sum    <= '0;
      eof_seen       <= 1'b0;
      error_flag     <= 1'b0;
    end else if (step) begin
      char_position  <= char_position_next;
      high_nibble    <= high_nibble_next;
      rec_len        <= rec_len_next;
      record_address <= record_address_next;
      record_type    <= record_type_next;
      running_sum    <= running_sum_next;
      eof_seen       <= eof_seen_next;
      error_flag     <= error_flag_next;
    end
  end

endmodule

/* hw/rtl/ihex_out_stage.sv */
// Result register that holds one word until the downstream side takes it.
module ihex_out_stage
  import ihex_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    free,
  ihex_result_if.source result_out
);

  logic    held_valid;
  result_t held;

  assign free                 = !held_valid || result_out.ready;
  assign result_out.valid     = held_valid;
  assign result_out.status    = held.status;
  assign result_out.address   = held.address;
  assign result_out.data_byte = held.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (free) begin
      held_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

endmodule

/* hw/rtl/intel_hex_record_parser_top.sv */
// Intel HEX record parser: one character word per cycle, results on a registered port.
// A word is registered in the input stage, then its result in the result stage.
// Throughput: one input word per cycle while the result side is not stalled.
// Stalls on the result side hold the input register and the parser state in place.
// Synchronous reset returns the parser to waiting for a colon with no error or eof.
module intel_hex_record_parser_top
  import ihex_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ihex_char_if.sink     char_in,
  ihex_result_if.source result_out
);

  logic    item_valid;
  item_t   item;
  logic    free;
  logic    step;
  logic    res_valid;
  result_t res;

  assign step = item_valid && free;

  ihex_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .advance    (free),
    .item_valid (item_valid),
    .item       (item)
  );

  ihex_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ihex_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step && res_valid),
    .res        (res),
    .free       (free),
    .result_out (result_out)
  );

endmodule

/* tb/tb_intel_hex_record_parser_top.sv */
// Self-checking testbench: streams Intel HEX files into the parser and checks every result word.
module tb_intel_hex_record_parser_top
  import ihex_pkg::*;
();

  localparam int PHASE_WORDS = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_NONHEX, FLAW_CUT} flaw_t;

  logic clk;
  logic rst;

  ihex_char_if   char_in ();
  ihex_result_if result_out ();

  intel_hex_record_parser_top dut (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .result_out (result_out)
  );

  item_t   hex_stream [$];
  result_t parse_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int words_queued = 0;
  int files_queued = 0;
  int words_checked = 0;
  int data_bytes_seen = 0;
  int quiet_cycles = 0;

  // Parser state mirrored by the predictor.
  logic [9:0]  pos = POS_WAIT;
  logic [3:0]  hi_nib = '0;
  logic [7:0]  cnt = '0;
  logic [15:0] rec_addr = '0;
  logic [7:0]  rec_type = '0;
  logic [7:0]  sum = '0;
  bit          eof_seen = 1'b0;
  bit          err_flag = 1'b0;

  item_t   next_word;
  result_t got_word;
  result_t exp_word;

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
    nib = '0;
    if (c >= "0" && c <= "9") begin
      nib = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      nib = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      nib = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the mirrored parser by one word; returns 1 when a result word is due.
  function automatic bit parse_char(input logic kind, input logic [7:0] c, output result_t r);
    logic [3:0] nib;
    logic [9:0] d;
    logic [7:0] value;
    bit done_ok;
    r = '0;
    if (kind == KIND_END) begin
      done_ok = !err_flag && eof_seen && (pos == POS_WAIT || pos == POS_TAIL);
      pos = POS_WAIT;
      hi_nib = '0;
      cnt = '0;
      rec_addr = '0;
      rec_type = '0;
      sum = '0;
      eof_seen = 1'b0;
      err_flag = 1'b0;
      r.status = done_ok ? ST_DONE_OK : ST_DONE_FAIL;
      return 1'b1;
    end
    if (err_flag || eof_seen) return 1'b0;
    if (pos == POS_TAIL) begin
      if (c == CH_CR || c == CH_LF) pos = POS_WAIT;
      return 1'b0;
    end
    if (pos == POS_WAIT) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) return 1'b0;
      if (c != CH_COLON) begin
        err_flag = 1'b1;
        r.status = ST_FORMAT;
        return 1'b1;
      end
      pos = POS_FIRST;
      sum = '0;
      cnt = '0;
      rec_addr = '0;
      rec_type = '0;
      hi_nib = '0;
      return 1'b0;
    end
    if (!hex_nibble(c, nib)) begin
      err_flag = 1'b1;
      pos = POS_WAIT;
      r.status = ST_FORMAT;
      return 1'b1;
    end
    d = pos - 10'd1;
    pos = pos + 10'd1;
    if (!d[0]) begin
      hi_nib = nib;
      return 1'b0;
    end
    value = {hi_nib, nib};
    sum = sum + value;
    if (d == D_COUNT_LO) begin
      cnt = value;
    end else if (d == D_ADDR_HI_LO) begin
      rec_addr = {value, 8'h00};
    end else if (d == D_ADDR_LO_LO) begin
      rec_addr = rec_addr | {8'h00, value};
    end else if (d == D_TYPE_LO) begin
      rec_type = value;
      if (value != REC_DATA && value != REC_EOF) begin
        err_flag = 1'b1;
        pos = POS_WAIT;
        r.status = ST_FORMAT;
        return 1'b1;
      end
    end else if (d < CHK_BASE + {1'b0, cnt, 1'b0}) begin
      // Bytes of an eof record only feed the checksum.
      if (rec_type == REC_DATA) begin
        r.status = ST_DATA_BYTE;
        r.address = rec_addr + 16'((d - FIRST_DATA_DIGIT) >> 1);
        r.data_byte = value;
        return 1'b1;
      end
    end else begin
      r.address = rec_addr;
      if (sum != 8'h00) begin
        err_flag = 1'b1;
        pos = POS_WAIT;
        r.status = ST_CHECKSUM;
        return 1'b1;
      end
      pos = POS_TAIL;
      if (rec_type == REC_EOF) begin
        eof_seen = 1'b1;
        r.status = ST_EOF_OK;
      end else begin
        r.status = ST_DATA_OK;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    // Keep the log readable on a badly broken build; every mismatch still counts.
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_char(input logic [7:0] c);
    hex_stream.push_back('{kind: KIND_CHAR, char_code: c});
    words_queued++;
  endtask

  task automatic push_end();
    hex_stream.push_back('{kind: KIND_END, char_code: 8'($urandom)});
    words_queued++;
    files_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Sends one record as digit pairs; a flaw breaks it at a random digit or spoils the checksum.
  task automatic push_record(input logic [7:0] rtype, input logic [15:0] addr,
                             input int nbytes, input flaw_t flaw);
    logic [7:0] rec [$];
    logic [7:0] total;
    logic [7:0] c;
    logic [3:0] nib;
    int stop_digit;
    rec = {8'(nbytes), addr[15:8], addr[7:0], rtype};
    repeat (nbytes) rec.push_back(8'($urandom));
    total = '0;
    foreach (rec[i]) total += rec[i];
    rec.push_back(8'h00 - total);
    if (flaw == FLAW_SUM) rec[rec.size()-1] ^= 8'($urandom_range(1, 255));
    if (flaw == FLAW_NONHEX || flaw == FLAW_CUT) begin
      stop_digit = $urandom_range(0, 2 * rec.size() - 1);
    end else begin
      stop_digit = 2 * rec.size();
    end
    push_char(CH_COLON);
    for (int k = 0; k < stop_digit; k++) begin
      nib = k[0] ? rec[k/2][3:0] : rec[k/2][7:4];
      if (nib < 4'd10) begin
        push_char("0" + 8'(nib));
      end else begin
        push_char(($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10);
      end
    end
    if (flaw == FLAW_NONHEX) begin
      if ($urandom_range(0, 3) == 0) begin
        c = $urandom_range(0, 1) ? CH_CR : CH_LF;
      end else begin
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c, nib));
      end
      push_char(c);
    end
  endtask

  task automatic gen_file();
    int nrec;
    int pick;
    int nbytes;
    logic [7:0] rtype;
    flaw_t flaw;
    bit cut;
    nrec = $urandom_range(0, 4);
    cut = 1'b0;
    for (int r = 0; r < nrec && !cut; r++) begin
      if ($urandom_range(0, 9) == 0) push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      rtype = ($urandom_range(0, 99) < 4) ? 8'($urandom_range(2, 255)) : REC_DATA;
      pick = $urandom_range(0, 99);
      nbytes = (pick < 85) ? $urandom_range(0, 6) : (pick < 99) ? $urandom_range(7, 32) : 255;
      pick = $urandom_range(0, 99);
      flaw = (pick < 90) ? FLAW_NONE : (pick < 94) ? FLAW_SUM :
             (pick < 98) ? FLAW_NONHEX : FLAW_CUT;
      push_record(rtype, 16'($urandom), nbytes, flaw);
      cut = (flaw == FLAW_CUT);
      if (!cut) begin
        // Trailing junk after the checksum is skipped up to the line end.
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_char(8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 40) push_text("\r\n");
        else if (pick < 70) push_char(CH_LF);
        else if (pick < 90) push_char(CH_CR);
        else if (pick < 97) push_text("\n\n");
      end
    end
    if (!cut) begin
      if ($urandom_range(0, 9) != 0) begin
        push_record(REC_EOF, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0, FLAW_NONE);
        if ($urandom_range(0, 1) == 0) push_text("\r\n");
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) push_char(8'($urandom));
    end
    push_end();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    char_in.valid = 1'b0;
    char_in.kind = KIND_CHAR;
    char_in.char_code = 8'h00;
    result_out.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: presents queued words and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      char_in.valid <= 1'b0;
    end else begin
      if (char_in.valid && char_in.ready) begin
        if (parse_char(char_in.kind, char_in.char_code, exp_word))
          parse_results.push_back(exp_word);
      end
      if (!char_in.valid || char_in.ready) begin
        if (hex_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = hex_stream.pop_front();
          char_in.valid <= 1'b1;
          char_in.kind <= next_word.kind;
          char_in.char_code <= next_word.char_code;
        end else begin
          char_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: applies back-pressure and checks each result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (result_out.valid && result_out.ready) begin
        got_word.status = status_t'(result_out.status);
        got_word.address = result_out.address;
        got_word.data_byte = result_out.data_byte;
        words_checked++;
        if (got_word.status == ST_DATA_BYTE) data_bytes_seen++;
        if (parse_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word status=%0d address=%h data=%h",
                                    got_word.status, got_word.address, got_word.data_byte));
        end else begin
          exp_word = parse_results.pop_front();
          if (got_word.status !== exp_word.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result_out.status, exp_word.status));
          if (got_word.address !== exp_word.address)
            report_mismatch($sformatf("address %h, expected %h (status %0d)",
                                      got_word.address, exp_word.address, exp_word.status));
          if (got_word.data_byte !== exp_word.data_byte)
            report_mismatch($sformatf("data byte %h, expected %h at address %h",
                                      got_word.data_byte, exp_word.data_byte,
                                      exp_word.address));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((char_in.valid && char_in.ready) || (result_out.valid && result_out.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct = 24;
          recv_stall_pct = 24;
        end
      endcase
      if (ph == 0) begin
        // End straight after reset: no eof record, so the file fails.
        push_end();
        // Stray character before any colon, then ignored input until the end word.
        push_char(8'hFF);
        push_char(8'h00);
        push_end();
        // Whitespace, eof record carrying a data byte, junk after it.
        push_text(" \t\r\n:01000001AA54x\rZ");
        push_end();
        // Unknown record type, then a non-hex digit inside a record.
        push_text(":00000002");
        push_end();
        push_text(":0G");
        push_end();
      end
      if (ph == 3) begin
        // Largest record, with the address wrapping past the top of the space.
        push_record(REC_DATA, 16'hFF80, 255, FLAW_NONE);
        push_text("\r\n:00000001FF\r\n");
        push_end();
      end
      goal = words_queued + PHASE_WORDS;
      while (words_queued < goal) gen_file();
      while (hex_stream.size() != 0 || char_in.valid || parse_results.size() != 0)
        @(negedge clk);
    end
    repeat (8) @(posedge clk);
    $display("Sent %0d input words in %0d files under four idle/stall mixes.",
             words_queued, files_queued);
    $display("Checked %0d result words, %0d of them data bytes; %0d mismatches.",
             words_checked, data_bytes_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
